// File: design/hrsq_pkg.sv
// Types, constants and helper functions for the head rotation scroll quantizer.
package hrsq_pkg;

	// Datapath widths
	localparam int QW   = 16;  // Q1.14 quaternion component
	localparam int RW   = 20;  // relative quaternion component after rounding
	localparam int AW   = 43;  // product accumulator
	localparam int CW   = 46;  // CORDIC vector component
	localparam int ANGW = 21;  // CORDIC angle, Q16 radians
	localparam int DEGW = 17;  // angle, Q13 radians
	localparam int DIFW = 18;  // angle difference
	localparam int MAW  = 34;  // multiplier operand A
	localparam int MBW  = 30;  // multiplier operand B
	localparam int PW   = 64;  // multiplier product
	localparam int SQW  = 58;  // square root remainder and root
	localparam int CNTW = 5;   // sequencer step counter
	localparam int ATAN_ENTRIES = 24;

	localparam logic signed [ANGW-1:0] PI_Q16          = 21'sd205887;
	localparam logic signed [MBW-1:0]  DEG_PER_RAD_Q20 = 30'sd60078979;
	localparam logic signed [29:0]     ONE_Q28         = 30'sd268435456;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_VGAIN  = 2'd1,
		REG_HGAIN  = 2'd2,
		REG_THRESH = 2'd3
	} reg_idx_t;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_QMUL  = 12'b000000000010,
		S_QRND  = 12'b000000000100,
		S_FMUL  = 12'b000000001000,
		S_FEND  = 12'b000000010000,
		S_SQ    = 12'b000000100000,
		S_SQRT  = 12'b000001000000,
		S_CINIT = 12'b000010000000,
		S_CITER = 12'b000100000000,
		S_CFIN  = 12'b001000000000,
		S_SCALE = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} state_t;

	// Arctangent of 2^-i in Q16 radians
	function automatic logic signed [ANGW-1:0] atan_q16(input logic [CNTW-1:0] i);
		logic signed [ANGW-1:0] v;
		case (i)
			5'd0:    v = 21'sd51472;
			5'd1:    v = 21'sd30386;
			5'd2:    v = 21'sd16055;
			5'd3:    v = 21'sd8150;
			5'd4:    v = 21'sd4091;
			5'd5:    v = 21'sd2047;
			5'd6:    v = 21'sd1024;
			5'd7:    v = 21'sd512;
			5'd8:    v = 21'sd256;
			5'd9:    v = 21'sd128;
			5'd10:   v = 21'sd64;
			5'd11:   v = 21'sd32;
			5'd12:   v = 21'sd16;
			5'd13:   v = 21'sd8;
			5'd14:   v = 21'sd4;
			5'd15:   v = 21'sd2;
			5'd16:   v = 21'sd1;
			default: v = 21'sd0;
		endcase
		return v;
	endfunction

	// Round Q28 accumulator to Q14, half away from zero
	function automatic logic signed [RW-1:0] rnd14(input logic signed [AW-1:0] v);
		logic signed [AW:0] e;
		logic signed [AW:0] m;
		e = {v[AW-1], v};
		if (!v[AW-1]) begin
			m = (e + (AW+1)'(8192)) >>> 14;
		end else begin
			m = -((-e + (AW+1)'(8192)) >>> 14);
		end
		return m[RW-1:0];
	endfunction

	// Round Q16 angle to Q13, half away from zero
	function automatic logic signed [DEGW-1:0] rnd3(input logic signed [ANGW-1:0] v);
		logic signed [ANGW:0] e;
		logic signed [ANGW:0] m;
		e = {v[ANGW-1], v};
		if (!v[ANGW-1]) begin
			m = (e + (ANGW+1)'(4)) >>> 3;
		end else begin
			m = -((-e + (ANGW+1)'(4)) >>> 3);
		end
		return m[DEGW-1:0];
	endfunction

	// Shift the degree product right by 33 with rounding, then saturate to 32 bits
	function automatic logic signed [31:0] rnd33_sat(input logic signed [PW-1:0] v);
		logic signed [PW:0] e;
		logic signed [PW:0] m;
		e = {v[PW-1], v};
		if (!v[PW-1]) begin
			m = (e + ((PW+1)'(1) <<< 32)) >>> 33;
		end else begin
			m = -((-e + ((PW+1)'(1) <<< 32)) >>> 33);
		end
		if (m > (PW+1)'(64'sh7FFFFFFF)) begin
			return 32'sh7FFFFFFF;
		end else if (m < -((PW+1)'(64'sh80000000))) begin
			return 32'sh80000000;
		end
		return m[31:0];
	endfunction

endpackage

// File: design/head_rotation_scroll_quantizer.sv
// Top level of the head rotation scroll quantizer: sequencer, shared multiplier, root and CORDIC.
//
// Each enabled sample holds the block from its transfer until its result is ready. In that
// time 16 pipelined products form the relative quaternion, 8 more form the forward vector, one
// squares the clamped pitch sine, a one-bit-per-cycle square root follows, the CORDIC unit
// runs CORDIC_STEPS iterations twice (pitch, then yaw), and 4 products scale both changes to
// degrees times gain. The one signed 34x30 multiplier and the one CORDIC unit are shared by
// these steps. The block takes one item at a time; arm items and samples that arrive while
// disabled are taken in the idle state without starting the sequencer.
// A result waits in the output register until it is transferred; the next result holds the sequencer until then.
module head_rotation_scroll_quantizer #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [15:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        kind,
	input  logic signed [15:0]          rot_w,
	input  logic signed [15:0]          rot_x,
	input  logic signed [15:0]          rot_y,
	input  logic signed [15:0]          rot_z,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          vertical_delta,
	output logic signed [31:0]          horizontal_delta
);
	import hrsq_pkg::*;

	localparam logic [CNTW-1:0] LAST_STEP = CNTW'(CORDIC_STEPS - 1);

	state_t state_q;
	logic [CNTW-1:0] cnt_q;

	// Configuration registers
	logic                   enable_q;
	logic signed [15:0]     vgain_q;
	logic signed [15:0]     hgain_q;
	logic [14:0]            thresh_q;

	// Reference, sample and last angles
	logic signed [QW-1:0]   ref_q [4];
	logic signed [QW-1:0]   smp_q [4];
	logic signed [15:0]     last_pitch_q;
	logic signed [15:0]     last_yaw_q;

	// Shared multiplier and accumulators
	logic signed [MAW-1:0]  mul_a;
	logic signed [MBW-1:0]  mul_b;
	logic                   mul_iss;
	logic [1:0]             mul_sel;
	logic                   mul_neg;
	logic                   mul_clr;
	logic signed [PW-1:0]   p_q;
	logic                   acc_en_q;
	logic [1:0]             acc_sel_q;
	logic                   acc_neg_q;
	logic                   acc_clr_q;
	logic signed [AW-1:0]   acc_q [4];
	logic signed [AW-1:0]   p_acc;
	logic signed [RW-1:0]   r_q [4];

	// Forward vector and root
	logic signed [CW-1:0]   fx_q;
	logic signed [CW-1:0]   nfz_q;
	logic signed [29:0]     yc_q;
	logic [SQW-1:0]         rem_q;
	logic [SQW-1:0]         res_q;
	logic [SQW-1:0]         sq_bit;
	logic [SQW-1:0]         sq_trial;

	// CORDIC unit
	logic                   sel_yaw_q;
	logic                   zero_q;
	logic signed [CW-1:0]   cx_q;
	logic signed [CW-1:0]   cy_q;
	logic signed [ANGW-1:0] ang_q;
	logic signed [CW-1:0]   cx_in;
	logic signed [CW-1:0]   cy_in;
	logic signed [CW-1:0]   cdx;
	logic signed [CW-1:0]   cdy;
	logic signed [DEGW-1:0] ang_rnd;
	logic signed [DEGW-1:0] pitch_q;
	logic signed [DEGW-1:0] yaw_q;

	// Angle changes and scaled amounts
	logic signed [DIFW-1:0] dv;
	logic signed [DIFW-1:0] dh;
	logic [DIFW-1:0]        dv_abs;
	logic [DIFW-1:0]        dh_abs;
	logic                   pass_v;
	logic                   pass_h;
	logic signed [31:0]     scaled;
	logic signed [31:0]     vd_q;
	logic signed [31:0]     hd_q;
	logic                   out_valid_q;
	logic signed [31:0]     vout_q;
	logic signed [31:0]     hout_q;

	assign in_ready         = (state_q == S_IDLE);
	assign out_valid        = out_valid_q;
	assign vertical_delta   = vout_q;
	assign horizontal_delta = hout_q;

	// Angle changes against the last stored angles
	assign dv     = DIFW'(pitch_q) - DIFW'(last_pitch_q);
	assign dh     = DIFW'(yaw_q) - DIFW'(last_yaw_q);
	assign dv_abs = dv[DIFW-1] ? DIFW'(-dv) : DIFW'(dv);
	assign dh_abs = dh[DIFW-1] ? DIFW'(-dh) : DIFW'(dh);
	assign pass_v = dv_abs >= DIFW'(thresh_q);
	assign pass_h = dh_abs >= DIFW'(thresh_q);
	assign scaled = rnd33_sat(p_q);
	assign p_acc  = p_q[AW-1:0];

	// Square root step
	assign sq_bit   = SQW'(1) << {cnt_q, 1'b0};
	assign sq_trial = res_q + sq_bit;

	// CORDIC operand selection and shifts
	assign cx_in   = sel_yaw_q ? nfz_q : CW'($signed({1'b0, res_q[28:0]}));
	assign cy_in   = sel_yaw_q ? fx_q : CW'(yc_q);
	assign cdx     = cy_q >>> cnt_q;
	assign cdy     = cx_q >>> cnt_q;
	assign ang_rnd = zero_q ? '0 : rnd3(ang_q);

	// Select multiplier operands for the current sequencer step
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_iss = 1'b0;
		mul_sel = 2'd0;
		mul_neg = 1'b0;
		mul_clr = 1'b0;
		unique case (state_q)
			S_QMUL: begin
				if (!cnt_q[4]) begin
					mul_iss = 1'b1;
					mul_a   = MAW'(ref_q[cnt_q[1:0]]);
					mul_b   = MBW'(smp_q[cnt_q[1:0] ^ cnt_q[3:2]]);
					mul_sel = cnt_q[3:2];
					mul_clr = (cnt_q[1:0] == 2'd0);
					case (cnt_q[3:2])
						2'd0:    mul_neg = (cnt_q[1:0] != 2'd0);
						2'd1:    mul_neg = (cnt_q[1:0] == 2'd3);
						2'd2:    mul_neg = (cnt_q[1:0] == 2'd1);
						default: mul_neg = (cnt_q[1:0] == 2'd2);
					endcase
				end
			end
			S_FMUL: begin
				if (cnt_q < 5'd8) begin
					mul_iss = 1'b1;
					case (cnt_q[2:0])
						3'd0: begin
							mul_a = MAW'(r_q[1]); mul_b = MBW'(r_q[3]);
							mul_sel = 2'd0; mul_clr = 1'b1;
						end
						3'd1: begin
							mul_a = MAW'(r_q[0]); mul_b = MBW'(r_q[2]);
							mul_sel = 2'd0;
						end
						3'd2: begin
							mul_a = MAW'(r_q[0]); mul_b = MBW'(r_q[1]);
							mul_sel = 2'd1; mul_clr = 1'b1;
						end
						3'd3: begin
							mul_a = MAW'(r_q[2]); mul_b = MBW'(r_q[3]);
							mul_sel = 2'd1; mul_neg = 1'b1;
						end
						3'd4: begin
							mul_a = MAW'(r_q[1]); mul_b = MBW'(r_q[1]);
							mul_sel = 2'd2; mul_clr = 1'b1;
						end
						3'd5: begin
							mul_a = MAW'(r_q[2]); mul_b = MBW'(r_q[2]);
							mul_sel = 2'd2;
						end
						3'd6: begin
							mul_a = MAW'(r_q[0]); mul_b = MBW'(r_q[0]);
							mul_sel = 2'd2; mul_neg = 1'b1;
						end
						default: begin
							mul_a = MAW'(r_q[3]); mul_b = MBW'(r_q[3]);
							mul_sel = 2'd2; mul_neg = 1'b1;
						end
					endcase
				end
			end
			S_SQ: begin
				mul_a = MAW'(yc_q);
				mul_b = MBW'(yc_q);
			end
			S_SCALE: begin
				case (cnt_q)
					5'd0: begin
						mul_a = MAW'(dv); mul_b = MBW'(vgain_q);
					end
					5'd1, 5'd3: begin
						mul_a = p_q[MAW-1:0]; mul_b = DEG_PER_RAD_Q20;
					end
					5'd2: begin
						mul_a = MAW'(dh); mul_b = MBW'(hgain_q);
					end
					default: begin
						mul_a = '0; mul_b = '0;
					end
				endcase
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			vgain_q  <= 16'sd256;
			hgain_q  <= 16'sd256;
			thresh_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_VGAIN:  vgain_q  <= $signed(cfg_data);
				REG_HGAIN:  hgain_q  <= $signed(cfg_data);
				REG_THRESH: thresh_q <= cfg_data[14:0];
				default:    enable_q <= enable_q;
			endcase
		end
	end

	// Multiplier product and accumulate controls, registered behind the issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_q <= 1'b0;
		end else begin
			acc_en_q <= mul_iss;
		end
	end

	always_ff @(posedge clk) begin
		p_q       <= mul_a * mul_b;
		acc_sel_q <= mul_sel;
		acc_neg_q <= mul_neg;
		acc_clr_q <= mul_clr;
		if (acc_en_q) begin
			acc_q[acc_sel_q] <= (acc_clr_q ? AW'(0) : acc_q[acc_sel_q])
				+ (acc_neg_q ? -p_acc : p_acc);
		end
	end

	// Sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			ref_q[0]     <= 16'sd16384;
			ref_q[1]     <= '0;
			ref_q[2]     <= '0;
			ref_q[3]     <= '0;
			last_pitch_q <= '0;
			last_yaw_q   <= '0;
			out_valid_q  <= 1'b0;
			sel_yaw_q    <= 1'b0;
		end else begin
			// Drop the result once transferred
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (kind) begin
							// Arm: store the conjugate, clear both last angles
							ref_q[0]     <= rot_w;
							ref_q[1]     <= (rot_x == -16'sd32768) ? 16'sd32767 : -rot_x;
							ref_q[2]     <= (rot_y == -16'sd32768) ? 16'sd32767 : -rot_y;
							ref_q[3]     <= (rot_z == -16'sd32768) ? 16'sd32767 : -rot_z;
							last_pitch_q <= '0;
							last_yaw_q   <= '0;
						end else if (enable_q) begin
							smp_q[0] <= rot_w;
							smp_q[1] <= rot_x;
							smp_q[2] <= rot_y;
							smp_q[3] <= rot_z;
							cnt_q    <= '0;
							state_q  <= S_QMUL;
						end
					end
				end
				S_QMUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q[4]) begin
						state_q <= S_QRND;
					end
				end
				S_QRND: begin
					for (int k = 0; k < 4; k++) begin
						r_q[k] <= rnd14(acc_q[k]);
					end
					cnt_q   <= '0;
					state_q <= S_FMUL;
				end
				S_FMUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd8) begin
						state_q <= S_FEND;
					end
				end
				S_FEND: begin
					// Forward vector, pitch sine clamped to one
					fx_q  <= -CW'($signed({acc_q[0], 1'b0}));
					nfz_q <= -CW'(acc_q[2]);
					if ($signed({acc_q[1], 1'b0}) > (AW+1)'(ONE_Q28)) begin
						yc_q <= ONE_Q28;
					end else if ($signed({acc_q[1], 1'b0}) < -((AW+1)'(ONE_Q28))) begin
						yc_q <= -ONE_Q28;
					end else begin
						yc_q <= {acc_q[1][28:0], 1'b0};
					end
					cnt_q   <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd1) begin
						rem_q   <= (SQW'(1) << 56) - SQW'(p_q[56:0]);
						res_q   <= '0;
						cnt_q   <= 5'd28;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					// One root bit per cycle
					if (rem_q >= sq_trial) begin
						rem_q <= rem_q - sq_trial;
						res_q <= (res_q >> 1) + sq_bit;
					end else begin
						res_q <= res_q >> 1;
					end
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						sel_yaw_q <= 1'b0;
						state_q   <= S_CINIT;
					end
				end
				S_CINIT: begin
					// Fold the left half plane onto the right
					zero_q <= (cx_in == '0) && (cy_in == '0);
					if (cx_in[CW-1]) begin
						ang_q <= cy_in[CW-1] ? -PI_Q16 : PI_Q16;
						cx_q  <= -cx_in;
						cy_q  <= -cy_in;
					end else begin
						ang_q <= '0;
						cx_q  <= cx_in;
						cy_q  <= cy_in;
					end
					cnt_q   <= '0;
					state_q <= S_CITER;
				end
				S_CITER: begin
					if (!cy_q[CW-1] && (cy_q != '0)) begin
						cx_q  <= cx_q + cdx;
						cy_q  <= cy_q - cdy;
						ang_q <= ang_q + atan_q16(cnt_q);
					end else begin
						cx_q  <= cx_q - cdx;
						cy_q  <= cy_q + cdy;
						ang_q <= ang_q - atan_q16(cnt_q);
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST_STEP) begin
						state_q <= S_CFIN;
					end
				end
				S_CFIN: begin
					if (sel_yaw_q) begin
						yaw_q   <= ang_rnd;
						cnt_q   <= '0;
						state_q <= S_SCALE;
					end else begin
						pitch_q   <= ang_rnd;
						sel_yaw_q <= 1'b1;
						state_q   <= S_CINIT;
					end
				end
				S_SCALE: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd2) begin
						if (!pass_v) begin
							vd_q <= '0;
						end else if (scaled == 32'sh80000000) begin
							vd_q <= 32'sh7FFFFFFF;
						end else begin
							vd_q <= -scaled;
						end
					end
					if (cnt_q == 5'd4) begin
						hd_q    <= pass_h ? scaled : 32'sd0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Advance the last angles and hand over the result
					if ((vd_q == '0) && (hd_q == '0)) begin
						if (pass_v) last_pitch_q <= pitch_q[15:0];
						if (pass_h) last_yaw_q   <= yaw_q[15:0];
						state_q <= S_IDLE;
					end else if (!out_valid_q || out_ready) begin
						if (pass_v) last_pitch_q <= pitch_q[15:0];
						if (pass_h) last_yaw_q   <= yaw_q[15:0];
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && ((vd_q != '0) || (hd_q != '0))
			&& (!out_valid_q || out_ready)) begin
			vout_q <= vd_q;
			hout_q <= hd_q;
		end
	end

endmodule

// File: design/hrsq_checker.sv
// Port-level checker for the head rotation scroll quantizer, with its bind.
module hrsq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                kind,
	input logic                out_valid,
	input logic                out_ready,
	input logic signed [31:0]  vertical_delta,
	input logic signed [31:0]  horizontal_delta
);

	// A result held back keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vertical_delta)
			&& $stable(horizontal_delta))
		else $error("result changed while stalled");

	// A result never carries two zero amounts
	a_out_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (vertical_delta != 0) || (horizontal_delta != 0))
		else $error("zero result emitted");

	// A new result only follows busy cycles
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without work");

	// An arm transfer completes at once
	a_arm_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind |=> in_ready)
		else $error("arm item held the block");

endmodule

bind head_rotation_scroll_quantizer hrsq_checker u_hrsq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.kind             (kind),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.vertical_delta   (vertical_delta),
	.horizontal_delta (horizontal_delta)
);

// File: tb/sv/tb_head_rotation_scroll_quantizer.sv
// Self-checking testbench for the head rotation scroll quantizer, with its own angle predictor.
module tb_head_rotation_scroll_quantizer;
	timeunit 1ns;
	timeprecision 1ps;

	import hrsq_pkg::*;

	localparam int STEPS       = 16;
	localparam int SETTLE      = 250;
	localparam int ITEM_SAMPLE = 0;
	localparam int ITEM_ARM    = 1;

	typedef struct {
		int vert;
		int horiz;
	} wheel_t;

	typedef struct {
		bit              is_cfg;
		reg_idx_t        idx;
		logic [15:0]     data;
		bit              kind;
		shortint         w, x, y, z;
		bit              silent;  // no result may come from this row
	} row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [15:0]       cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic              kind;
	logic signed [15:0] rot_w, rot_x, rot_y, rot_z;
	logic              out_valid;
	logic              out_ready;
	logic signed [31:0] vertical_delta;
	logic signed [31:0] horizontal_delta;

	// Predictor state and register copies
	bit      pr_enable;
	int      pr_vgain, pr_hgain, pr_thresh;
	longint  ref_qw, ref_qx, ref_qy, ref_qz;
	int      last_pitch, last_yaw;

	wheel_t  pending_wheel[$];
	int      errors;
	bit      calm;
	real     hw, hx, hy, hz;

	const int atan_tab[24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

	row_t plan[] = '{
		'{0, REG_ENABLE, 16'd0, 0, 16384, 0, 0, 0, 1},
		'{0, REG_ENABLE, 16'd0, 0, -32768, -32768, -32768, -32768, 1},
		'{1, REG_ENABLE, 16'd1, 0, 0, 0, 0, 0, 0},
		'{0, REG_ENABLE, 16'd0, 0, 16384, 0, 0, 0, 1},
		'{0, REG_ENABLE, 16'd0, 0, 11585, 11585, 0, 0, 0},
		'{0, REG_ENABLE, 16'd0, 0, 11585, 0, 11585, 0, 0},
		'{0, REG_ENABLE, 16'd0, 0, 0, 0, 0, 0, 0},
		'{0, REG_ENABLE, 16'd0, 0, 16384, 16384, 16384, 16384, 0},
		'{0, REG_ENABLE, 16'd0, 0, -16384, 0, 0, 0, 0},
		'{0, REG_ENABLE, 16'd0, 1, 11585, -32768, -32768, -32768, 1},
		'{0, REG_ENABLE, 16'd0, 0, 11585, 16384, -16384, 0, 0},
		'{0, REG_ENABLE, 16'd0, 1, 16384, 0, 0, 0, 1},
		'{1, REG_VGAIN, 16'd0, 0, 0, 0, 0, 0, 0},
		'{0, REG_ENABLE, 16'd0, 0, 11585, 11585, 0, 0, 0},
		'{1, REG_THRESH, 16'd25736, 0, 0, 0, 0, 0, 0},
		'{0, REG_ENABLE, 16'd0, 0, 0, 0, 16384, 0, 0},
		'{0, REG_ENABLE, 16'd0, 0, 16384, 0, 0, 0, 0},
		'{1, REG_HGAIN, 16'h8000, 0, 0, 0, 0, 0, 0},
		'{1, REG_VGAIN, 16'h7FFF, 0, 0, 0, 0, 0, 0},
		'{1, REG_THRESH, 16'd0, 0, 0, 0, 0, 0, 0},
		'{0, REG_ENABLE, 16'd0, 0, 11585, -11585, 0, 0, 0},
		'{0, REG_ENABLE, 16'd0, 0, 0, 16384, 0, 0, 0},
		'{0, REG_ENABLE, 16'd0, 0, -32768, 32767, -32768, 32767, 0},
		'{0, REG_ENABLE, 16'd0, 1, 16384, 0, 0, 0, 1}
	};

	head_rotation_scroll_quantizer #(.CORDIC_STEPS(STEPS)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .rot_w(rot_w), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.vertical_delta(vertical_delta), .horizontal_delta(horizontal_delta)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Round a right shift half away from zero
	function automatic longint shift_round(longint v, int n);
		longint half;
		half = longint'(1) <<< (n - 1);
		if (v >= 0) return (v + half) >>> n;
		return -((-v + half) >>> n);
	endfunction

	function automatic longint floor_root(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	// Vectoring CORDIC, Q16 angle rounded to Q13 radians
	function automatic int angle_of(longint y, longint x);
		longint ang, dx, dy;
		ang = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			ang = (y >= 0) ? 205887 : -205887;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; ang += atan_tab[i];
			end else begin
				x -= dx; y += dy; ang -= atan_tab[i];
			end
		end
		return int'(shift_round(ang, 3));
	endfunction

	function automatic longint conj_part(longint v);
		return (v == -32768) ? 32767 : -v;
	endfunction

	function automatic int wheel_amount(int diff, int gain);
		longint r;
		r = shift_round(longint'(diff) * longint'(gain) * 64'sd60078979, 33);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return int'(r);
	endfunction

	// Advance the predictor by one transfer; returns 1 when a wheel result is due
	function automatic bit predict_wheel(bit k, shortint bw, shortint bx, shortint by, shortint bz);
		longint rw, rx, ry, rz, fx, fy, fz, yc;
		int pitch, yaw, dv, dh, vd, hd;
		wheel_t res;
		vd = 0;
		hd = 0;
		if (k == ITEM_ARM) begin
			ref_qw = bw;
			ref_qx = conj_part(bx);
			ref_qy = conj_part(by);
			ref_qz = conj_part(bz);
			last_pitch = 0;
			last_yaw = 0;
			return 0;
		end
		if (!pr_enable) return 0;
		rw = shift_round(ref_qw * bw - ref_qx * bx - ref_qy * by - ref_qz * bz, 14);
		rx = shift_round(ref_qw * bx + ref_qx * bw + ref_qy * bz - ref_qz * by, 14);
		ry = shift_round(ref_qw * by - ref_qx * bz + ref_qy * bw + ref_qz * bx, 14);
		rz = shift_round(ref_qw * bz + ref_qx * by - ref_qy * bx + ref_qz * bw, 14);
		fx = -2 * (rx * rz + rw * ry);
		fy = 2 * (rw * rx - ry * rz);
		fz = rx * rx + ry * ry - rw * rw - rz * rz;
		yc = fy;
		if (yc > (longint'(1) <<< 28)) yc = longint'(1) <<< 28;
		if (yc < -(longint'(1) <<< 28)) yc = -(longint'(1) <<< 28);
		pitch = angle_of(yc, floor_root((64'd1 << 56) - longint'(yc * yc)));
		yaw = angle_of(fx, -fz);
		dv = pitch - last_pitch;
		dh = yaw - last_yaw;
		if (((dv < 0) ? -dv : dv) >= pr_thresh) begin
			vd = wheel_amount(dv, pr_vgain);
			vd = (vd == 32'sh80000000) ? 32'sh7FFFFFFF : -vd;
			last_pitch = pitch;
		end
		if (((dh < 0) ? -dh : dh) >= pr_thresh) begin
			hd = wheel_amount(dh, pr_hgain);
			last_yaw = yaw;
		end
		if (vd == 0 && hd == 0) return 0;
		res.vert = vd;
		res.horiz = hd;
		pending_wheel.push_back(res);
		return 1;
	endfunction

	// Present one item and hold it until the transfer
	task automatic send_item(bit k, shortint w, shortint x, shortint y, shortint z, output bit due);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		rot_w <= w;
		rot_x <= x;
		rot_y <= y;
		rot_z <= z;
		do @(posedge clk); while (!in_ready);
		due = predict_wheel(k, w, x, y, z);
	endtask

	// Drain, let the block settle, then write one register
	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		in_valid <= 1'b0;
		while (pending_wheel.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ENABLE: pr_enable = value[0];
			REG_VGAIN:  pr_vgain = int'($signed(value));
			REG_HGAIN:  pr_hgain = int'($signed(value));
			REG_THRESH: pr_thresh = int'(value[14:0]);
		endcase
	endtask

	// Normalise the head orientation
	task automatic norm_head();
		real n;
		n = $sqrt(hw * hw + hx * hx + hy * hy + hz * hz);
		if (n < 1.0e-3) begin
			hw = 1.0; hx = 0.0; hy = 0.0; hz = 0.0;
		end else begin
			hw /= n; hx /= n; hy /= n; hz /= n;
		end
	endtask

	function automatic real jitter(int span);
		return real'($signed($urandom_range(0, 2 * span)) - span) / 1000.0;
	endfunction

	// Accept results and check them against the oldest prediction
	initial begin
		int stall;
		wheel_t want;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_wheel.size() == 0) begin
					$display("%0t: unexpected result vertical=%0d horizontal=%0d",
						$time, vertical_delta, horizontal_delta);
					errors++;
				end else begin
					want = pending_wheel.pop_front();
					if (vertical_delta !== want.vert) begin
						$display("%0t: vertical_delta expected %0d actual %0d",
							$time, want.vert, vertical_delta);
						errors++;
					end
					if (horizontal_delta !== want.horiz) begin
						$display("%0t: horizontal_delta expected %0d actual %0d",
							$time, want.horiz, horizontal_delta);
						errors++;
					end
				end
			end
			if (calm) begin
				out_ready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus: directed plan, then random phases
	initial begin
		bit due;
		int kind_pick;
		errors = 0;
		calm = 1'b0;
		pr_enable = 0; pr_vgain = 256; pr_hgain = 256; pr_thresh = 0;
		ref_qw = 16384; ref_qx = 0; ref_qy = 0; ref_qz = 0;
		last_pitch = 0; last_yaw = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = REG_ENABLE; cfg_data = '0;
		in_valid = 1'b0; kind = 1'b0;
		rot_w = '0; rot_x = '0; rot_y = '0; rot_z = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_item(plan[i].kind, plan[i].w, plan[i].x, plan[i].y, plan[i].z, due);
				if (plan[i].silent && due) begin
					$display("%0t: row %0d expected no result, predictor disagrees", $time, i);
					errors++;
				end
			end
		end

		hw = 1.0; hx = 0.0; hy = 0.0; hz = 0.0;
		for (int ph = 0; ph < 8; ph++) begin
			calm = (ph == 7);
			write_reg(REG_ENABLE, (ph == 3) ? 16'd0 : 16'd1);
			case (ph)
				0: write_reg(REG_VGAIN, 16'd256);
				1: write_reg(REG_VGAIN, 16'h8000);
				2: write_reg(REG_VGAIN, 16'h7FFF);
				default: write_reg(REG_VGAIN, 16'($urandom));
			endcase
			case (ph)
				0: write_reg(REG_HGAIN, 16'd256);
				1: write_reg(REG_HGAIN, 16'h7FFF);
				2: write_reg(REG_HGAIN, 16'h8000);
				4: write_reg(REG_HGAIN, 16'd0);
				default: write_reg(REG_HGAIN, 16'($urandom));
			endcase
			case (ph)
				0: write_reg(REG_THRESH, 16'd0);
				1: write_reg(REG_THRESH, 16'd25736);
				2: write_reg(REG_THRESH, 16'h7FFF);
				default: write_reg(REG_THRESH, 16'($urandom_range(0, 400)));
			endcase
			for (int n = 0; n < 200; n++) begin
				kind_pick = $urandom_range(0, 19);
				if (kind_pick == 0) begin
					// noise: any bit pattern, either kind
					send_item($urandom_range(0, 1), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), due);
				end else if (kind_pick == 1) begin
					// arm at a fresh random orientation
					hw = jitter(1000); hx = jitter(1000); hy = jitter(1000); hz = jitter(1000);
					norm_head();
					send_item(ITEM_ARM, shortint'($rtoi(hw * 16384.0)),
						shortint'($rtoi(hx * 16384.0)), shortint'($rtoi(hy * 16384.0)),
						shortint'($rtoi(hz * 16384.0)), due);
				end else begin
					// head drifts a little from its last pose
					hw += jitter(60); hx += jitter(60); hy += jitter(60); hz += jitter(60);
					norm_head();
					send_item(ITEM_SAMPLE, shortint'($rtoi(hw * 16384.0)),
						shortint'($rtoi(hx * 16384.0)), shortint'($rtoi(hy * 16384.0)),
						shortint'($rtoi(hz * 16384.0)), due);
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_wheel.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
design/hrsq_pkg.sv
design/head_rotation_scroll_quantizer.sv
design/hrsq_checker.sv
tb/sv/tb_head_rotation_scroll_quantizer.sv
